### rtl/rbei_pkg.sv
// Shared types, constants and the microcode program of the rigid body integrator.
`default_nettype none

package rbei_pkg;

	// Fixed field widths and default arithmetic settings.
	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int DT_FRAC         = 16;
	localparam int DAMP_Q16        = 64225;
	localparam int FIELD_W         = 32;
	localparam int DT_W            = 16;
	localparam int ACT_W           = 3;
	localparam int IMASS_W         = 32;
	localparam int UPC_W           = 5;
	localparam int CFG_IDX_W       = 1;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_IMASS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC = 1'b1;
	localparam logic [IMASS_W-1:0]   IMASS_RESET = 32'd65536;

	// Action codes carried by an input word.
	typedef enum logic [ACT_W-1:0] {
		ACT_FORCE   = 3'd0,
		ACT_TICK    = 3'd1,
		ACT_SET_POS = 3'd2,
		ACT_SET_VEL = 3'd3,
		ACT_SET_ROT = 3'd4
	} action_t;

	// Micro-operations of the datapath.
	typedef enum logic [2:0] {
		OP_DISP  = 3'd0,
		OP_MUL   = 3'd1,
		OP_ACC   = 3'd2,
		OP_LOAD  = 3'd3,
		OP_CLEAR = 3'd4,
		OP_NOP   = 3'd5
	} uop_t;

	// State register select.
	typedef enum logic [2:0] {
		R_POS_X = 3'd0,
		R_POS_Y = 3'd1,
		R_VEL_X = 3'd2,
		R_VEL_Y = 3'd3,
		R_ACC_X = 3'd4,
		R_ACC_Y = 3'd5,
		R_HEAD  = 3'd6,
		R_TURN  = 3'd7
	} rsel_t;

	// Multiplier operand selects and product shift select.
	typedef enum logic [1:0] {
		A_REG = 2'd0,
		A_VX  = 2'd1,
		A_VY  = 2'd2
	} asel_t;

	typedef enum logic [1:0] {
		B_IMASS = 2'd0,
		B_DT    = 2'd1,
		B_DAMP  = 2'd2
	} bsel_t;

	typedef enum logic {
		SH_FRAC = 1'b0,
		SH_DT   = 1'b1
	} shsel_t;

	// One control word of the program.
	typedef struct packed {
		uop_t   op;
		rsel_t  ra;
		asel_t  asrc;
		bsel_t  bsrc;
		shsel_t sh;
		logic   base_zero;
		logic   last;
	} ucw_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		ucw_t uw;
		logic exec;
		logic take;
		logic cap;
	} dp_ctl_t;

	// Entry points of the program routines.
	localparam logic [UPC_W-1:0] UA_DISP    = 5'd0;
	localparam logic [UPC_W-1:0] UA_FORCE   = 5'd1;
	localparam logic [UPC_W-1:0] UA_TICK    = 5'd5;
	localparam logic [UPC_W-1:0] UA_SET_POS = 5'd19;
	localparam logic [UPC_W-1:0] UA_SET_VEL = 5'd21;
	localparam logic [UPC_W-1:0] UA_SET_ROT = 5'd23;
	localparam logic [UPC_W-1:0] UA_NOP     = 5'd25;
	localparam logic [UPC_W-1:0] UA_LAST    = 5'd25;

	function automatic ucw_t mk(uop_t op, rsel_t ra, asel_t asrc, bsel_t bsrc, shsel_t sh,
			logic base_zero, logic last);
		ucw_t w;
		w.op        = op;
		w.ra        = ra;
		w.asrc      = asrc;
		w.bsrc      = bsrc;
		w.sh        = sh;
		w.base_zero = base_zero;
		w.last      = last;
		return w;
	endfunction

	// The control store. Each multiply is followed by the accumulate that consumes it.
	function automatic ucw_t urom(logic [UPC_W-1:0] a);
		ucw_t w;
		case (a)
			UA_DISP:             w = mk(OP_DISP,  R_POS_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			// Force: accel += force * inverse mass.
			UA_FORCE:            w = mk(OP_MUL,   R_ACC_X, A_VX,  B_IMASS, SH_FRAC, 1'b0, 1'b0);
			UA_FORCE + 5'd1:     w = mk(OP_ACC,   R_ACC_X, A_REG, B_IMASS, SH_FRAC, 1'b0, 1'b0);
			UA_FORCE + 5'd2:     w = mk(OP_MUL,   R_ACC_Y, A_VY,  B_IMASS, SH_FRAC, 1'b0, 1'b0);
			UA_FORCE + 5'd3:     w = mk(OP_ACC,   R_ACC_Y, A_REG, B_IMASS, SH_FRAC, 1'b0, 1'b1);
			// Tick: velocity, then position from the new velocity, heading, damping, then accel cleared.
			UA_TICK:             w = mk(OP_MUL,   R_ACC_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd1:      w = mk(OP_ACC,   R_VEL_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd2:      w = mk(OP_MUL,   R_ACC_Y, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd3:      w = mk(OP_ACC,   R_VEL_Y, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd4:      w = mk(OP_MUL,   R_VEL_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd5:      w = mk(OP_ACC,   R_POS_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd6:      w = mk(OP_MUL,   R_VEL_Y, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd7:      w = mk(OP_ACC,   R_POS_Y, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd8:      w = mk(OP_MUL,   R_TURN,  A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd9:      w = mk(OP_ACC,   R_HEAD,  A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd10:     w = mk(OP_MUL,   R_TURN,  A_REG, B_DAMP,  SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd11:     w = mk(OP_ACC,   R_TURN,  A_REG, B_DAMP,  SH_DT,   1'b1, 1'b0);
			UA_TICK + 5'd12:     w = mk(OP_CLEAR, R_ACC_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b0);
			UA_TICK + 5'd13:     w = mk(OP_CLEAR, R_ACC_Y, A_REG, B_DT,    SH_DT,   1'b0, 1'b1);
			// Setters.
			UA_SET_POS:          w = mk(OP_LOAD,  R_POS_X, A_VX,  B_DT,    SH_DT,   1'b0, 1'b0);
			UA_SET_POS + 5'd1:   w = mk(OP_LOAD,  R_POS_Y, A_VY,  B_DT,    SH_DT,   1'b0, 1'b1);
			UA_SET_VEL:          w = mk(OP_LOAD,  R_VEL_X, A_VX,  B_DT,    SH_DT,   1'b0, 1'b0);
			UA_SET_VEL + 5'd1:   w = mk(OP_LOAD,  R_VEL_Y, A_VY,  B_DT,    SH_DT,   1'b0, 1'b1);
			UA_SET_ROT:          w = mk(OP_LOAD,  R_HEAD,  A_VX,  B_DT,    SH_DT,   1'b0, 1'b0);
			UA_SET_ROT + 5'd1:   w = mk(OP_LOAD,  R_TURN,  A_VY,  B_DT,    SH_DT,   1'b0, 1'b1);
			UA_NOP:              w = mk(OP_NOP,   R_POS_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b1);
			default:             w = mk(OP_NOP,   R_POS_X, A_REG, B_DT,    SH_DT,   1'b0, 1'b1);
		endcase
		return w;
	endfunction

	// Dispatch jump: a frozen body skips force and tick.
	function automatic logic [UPC_W-1:0] entry_of(logic [ACT_W-1:0] act, logic frozen);
		logic [UPC_W-1:0] e;
		case (act)
			ACT_FORCE:   e = frozen ? UA_NOP : UA_FORCE;
			ACT_TICK:    e = frozen ? UA_NOP : UA_TICK;
			ACT_SET_POS: e = UA_SET_POS;
			ACT_SET_VEL: e = UA_SET_VEL;
			ACT_SET_ROT: e = UA_SET_ROT;
			default:     e = UA_NOP;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

### rtl/rigid_body_euler_integrator_core.sv
// Rigid body semi-implicit Euler integrator: 2D body state in signed fixed point.
//
// Input words (action, vec_x, vec_y, time_step) arrive on a valid/ready channel;
// each accepted word returns one result word with the full body state on a
// second valid/ready channel. Configuration registers (inverse_mass at index 0,
// is_static at index 1) are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// A small microcode program drives one shared multiplier and a saturating adder
// over a single read port of the state registers, one step per cycle. Every word
// first runs the dispatch step; a frozen body's force or tick, or an unused code,
// then runs only a no-op step. The tick routine is the long one: six products,
// each multiply and its accumulate taking a step, plus two clears.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; a routine that finishes while that register is
// full holds in its done step until the receiver takes the pending word.
// Reset clears the body state, sets inverse_mass to 1.0 and is_static to 0.
`default_nettype none

module rigid_body_euler_integrator_core
	import rbei_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic        [CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [IMASS_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic        [ACT_W-1:0]     action,
	input  wire logic signed [FIELD_W-1:0]   vec_x,
	input  wire logic signed [FIELD_W-1:0]   vec_y,
	input  wire logic        [DT_W-1:0]      time_step,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [FIELD_W-1:0]        out_position_x,
	output logic signed [FIELD_W-1:0]        out_position_y,
	output logic signed [FIELD_W-1:0]        out_velocity_x,
	output logic signed [FIELD_W-1:0]        out_velocity_y,
	output logic signed [FIELD_W-1:0]        out_heading,
	output logic signed [FIELD_W-1:0]        out_turn_rate
);

	logic [IMASS_W-1:0] imass_q;
	logic               static_q;
	dp_ctl_t            ctl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imass_q  <= IMASS_RESET;
			static_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMASS:  imass_q  <= cfg_data;
				CFG_STATIC: static_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Program sequencer.
	rbei_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.frozen    (static_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Arithmetic and state.
	rbei_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.vec_x          (vec_x),
		.vec_y          (vec_y),
		.time_step      (time_step),
		.inverse_mass   (imass_q),
		.out_position_x (out_position_x),
		.out_position_y (out_position_y),
		.out_velocity_x (out_velocity_x),
		.out_velocity_y (out_velocity_y),
		.out_heading    (out_heading),
		.out_turn_rate  (out_turn_rate)
	);

endmodule

`default_nettype wire

### rtl/rbei_seq.sv
// Microcode sequencer: step counter, dispatch jump and word handshakes.
`default_nettype none

module rbei_seq
	import rbei_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [ACT_W-1:0] action,
	input  wire logic             frozen,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output dp_ctl_t               ctl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} seq_state_t;

	seq_state_t       st_q, st_d;
	logic [UPC_W-1:0] upc_q, upc_d;
	logic [ACT_W-1:0] act_q;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;
	logic             take;
	logic             cap;
	ucw_t             uw;

	assign uw        = urom(upc_q);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (st_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign cap       = (st_q == ST_DONE) && slot_free;
	assign out_valid = out_valid_q;

	assign ctl.uw   = uw;
	assign ctl.exec = (st_q == ST_RUN);
	assign ctl.take = take;
	assign ctl.cap  = cap;

	// Next step and state.
	always_comb begin
		st_d  = st_q;
		upc_d = upc_q;
		case (st_q)
			ST_IDLE: begin
				if (take) begin
					st_d  = ST_RUN;
					upc_d = UA_DISP;
				end
			end
			ST_RUN: begin
				if (uw.op == OP_DISP) begin
					upc_d = entry_of(act_q, frozen);
				end else if (uw.last) begin
					st_d = ST_DONE;
				end else begin
					upc_d = upc_q + 5'd1;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// The output word stays valid until it is taken.
	always_comb begin
		out_valid_d = out_valid_q;
		if (cap) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			upc_q       <= UA_DISP;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			upc_q       <= upc_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Action code held for the dispatch step.
	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= action;
		end
	end

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (st_q == ST_RUN && upc_q == UA_DISP))
		else $error("accepted word did not start at the dispatch step");

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (upc_q <= UA_LAST))
		else $error("step counter left the program");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && uw.last && uw.op != OP_DISP) |=> (st_q == ST_DONE))
		else $error("routine end did not reach the done state");

	a_cap_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cap |=> (out_valid_q && st_q == ST_IDLE))
		else $error("captured result not presented");

	a_frozen_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && uw.op == OP_DISP && frozen
			&& (act_q == ACT_FORCE || act_q == ACT_TICK)) |=> (upc_q == UA_NOP))
		else $error("frozen body entered a force or tick routine");

endmodule

`default_nettype wire

### rtl/rbei_dp.sv
// Datapath: state registers, shared multiplier, saturating adder and output registers.
`default_nettype none

module rbei_dp
	import rbei_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dp_ctl_t                   ctl,
	input  wire logic signed [FIELD_W-1:0] vec_x,
	input  wire logic signed [FIELD_W-1:0] vec_y,
	input  wire logic        [DT_W-1:0]    time_step,
	input  wire logic        [IMASS_W-1:0] inverse_mass,
	output logic signed [FIELD_W-1:0]      out_position_x,
	output logic signed [FIELD_W-1:0]      out_position_y,
	output logic signed [FIELD_W-1:0]      out_velocity_x,
	output logic signed [FIELD_W-1:0]      out_velocity_y,
	output logic signed [FIELD_W-1:0]      out_heading,
	output logic signed [FIELD_W-1:0]      out_turn_rate
);

	localparam int AW = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;
	localparam int BW = IMASS_W + 1;
	localparam int PW = AW + BW;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] VMAX =
		$signed({{(SW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}});
	localparam logic signed [SW-1:0] VMIN = ~VMAX;

	logic signed [VALUE_WIDTH-1:0] st_q [8];
	logic signed [FIELD_W-1:0]     vx_q, vy_q;
	logic        [DT_W-1:0]        dt_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [VALUE_WIDTH-1:0] rd;
	logic signed [AW-1:0]          a_op;
	logic signed [BW-1:0]          b_op;
	logic signed [PW-1:0]          shf;
	logic signed [VALUE_WIDTH-1:0] base;
	logic signed [SW-1:0]          pre;
	logic signed [VALUE_WIDTH-1:0] sat;
	logic signed [VALUE_WIDTH-1:0] wdat;
	logic                          wen;

	// Low word of a stored value, sign-extended when the state is narrow.
	function automatic logic [FIELD_W-1:0] low_word(logic signed [VALUE_WIDTH-1:0] v);
		logic signed [AW-1:0] e;
		e = AW'(v);
		return e[FIELD_W-1:0];
	endfunction

	// Operands of the item, held while its routine runs.
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			vx_q <= vec_x;
			vy_q <= vec_y;
			dt_q <= time_step;
		end
	end

	// Single read port on the state registers.
	assign rd = st_q[ctl.uw.ra];

	// Multiplier operand selection.
	always_comb begin
		case (ctl.uw.asrc)
			A_VX:    a_op = AW'(vx_q);
			A_VY:    a_op = AW'(vy_q);
			default: a_op = AW'(rd);
		endcase
		case (ctl.uw.bsrc)
			B_IMASS: b_op = $signed({1'b0, inverse_mass});
			B_DAMP:  b_op = BW'(DAMP_Q16);
			default: b_op = $signed(BW'(dt_q));
		endcase
	end

	// Shared multiplier, product registered before the accumulate step.
	always_ff @(posedge clk) begin
		if (ctl.exec && ctl.uw.op == OP_MUL) begin
			prod_q <= a_op * b_op;
		end
	end

	// Floor shift of product plus target (or zero), or a load operand, then saturate.
	always_comb begin
		shf  = (ctl.uw.sh == SH_FRAC) ? (prod_q >>> FRAC_BITS) : (prod_q >>> DT_FRAC);
		base = ctl.uw.base_zero ? '0 : rd;
		case (ctl.uw.op)
			OP_LOAD: pre = (ctl.uw.asrc == A_VY) ? SW'(vy_q) : SW'(vx_q);
			default: pre = SW'(base) + SW'(shf);
		endcase
		if (pre > VMAX) begin
			sat = VMAX[VALUE_WIDTH-1:0];
		end else if (pre < VMIN) begin
			sat = VMIN[VALUE_WIDTH-1:0];
		end else begin
			sat = pre[VALUE_WIDTH-1:0];
		end
		wdat = (ctl.uw.op == OP_CLEAR) ? '0 : sat;
		wen  = ctl.exec && (ctl.uw.op == OP_ACC || ctl.uw.op == OP_LOAD
			|| ctl.uw.op == OP_CLEAR);
	end

	// Body state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				st_q[i] <= '0;
			end
		end else if (wen) begin
			st_q[ctl.uw.ra] <= wdat;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			out_position_x <= low_word(st_q[R_POS_X]);
			out_position_y <= low_word(st_q[R_POS_Y]);
			out_velocity_x <= low_word(st_q[R_VEL_X]);
			out_velocity_y <= low_word(st_q[R_VEL_Y]);
			out_heading    <= low_word(st_q[R_HEAD]);
			out_turn_rate  <= low_word(st_q[R_TURN]);
		end
	end

endmodule

`default_nettype wire
